### src/adds_pkg.sv
// ----------------------------------------------------------------------------
// adds_pkg
// Shared types and constants for the discrete Anderson-Darling statistic block.
// ----------------------------------------------------------------------------
package adds_pkg;

	// cdf values after conversion: Q0.32 with one = 2^32, so 33 bits
	localparam int QW = 33;
	localparam logic [QW-1:0] Q32_ONE = 33'h1_0000_0000;

	localparam int AW = 128;   // multiplicand, dividend and result width
	localparam int BW = 65;    // multiplier and divisor width

	localparam int MUL_STEPS = 33;   // multiplier operands are at most 33 bits
	localparam int DIV_STEPS = 97;   // dividend is at most 97 bits
	localparam int DIV_MSB   = 96;
	localparam int STEP_W    = 7;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	localparam logic [1:0] REG_EVENT_COUNT  = 2'd0;
	localparam logic [1:0] REG_STEP_EPSILON = 2'd1;
	localparam logic [1:0] REG_TAIL_LIMIT   = 2'd2;

	typedef struct packed {
		logic start;
		logic op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

endpackage

### src/adds_alu.sv
// ----------------------------------------------------------------------------
// adds_alu
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit a
// cycle. The result holds until the next start.
// ----------------------------------------------------------------------------
module adds_alu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  adds_pkg::alu_req_t        req,
	input  logic [adds_pkg::AW-1:0]   a,
	input  logic [adds_pkg::BW-1:0]   b,
	output adds_pkg::alu_rsp_t        rsp,
	output logic [adds_pkg::AW-1:0]   result
);

	logic [adds_pkg::AW-1:0]     x_q;
	logic [adds_pkg::BW-1:0]     y_q;
	logic [adds_pkg::AW-1:0]     acc_q;
	logic [adds_pkg::BW-1:0]     rem_q;
	logic [adds_pkg::STEP_W-1:0] cnt_q;
	logic                        op_q;
	logic                        done_q;

	logic [adds_pkg::BW:0] r2;
	logic [adds_pkg::BW:0] diff;
	logic                  ge;

	always_comb begin
		r2   = {rem_q, x_q[adds_pkg::DIV_MSB]};
		ge   = (r2 >= {1'b0, y_q});
		diff = r2 - {1'b0, y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			op_q   <= adds_pkg::OP_MUL;
		end else if (req.start) begin
			op_q   <= req.op;
			done_q <= 1'b0;
			cnt_q  <= (req.op == adds_pkg::OP_DIV) ?
				adds_pkg::STEP_W'(adds_pkg::DIV_STEPS) :
				adds_pkg::STEP_W'(adds_pkg::MUL_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == adds_pkg::STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= a;
			y_q   <= b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			x_q <= {x_q[adds_pkg::AW-2:0], 1'b0};
			case (op_q)
				adds_pkg::OP_DIV: begin
					rem_q <= ge ? diff[adds_pkg::BW-1:0] : r2[adds_pkg::BW-1:0];
					acc_q <= {acc_q[adds_pkg::AW-2:0], ge};
				end
				default: begin
					if (y_q[0])
						acc_q <= acc_q + x_q;
					y_q <= {1'b0, y_q[adds_pkg::BW-1:1]};
				end
			endcase
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.done = done_q;
	assign result   = acc_q;

endmodule

### src/anderson_darling_discrete_stat.sv
// steps: bin 0 runs the term products and divide; a later bin runs the tail
// product and, unless it ends the sum or has nothing to settle, the term products
// and divide; the last bin adds a second settle and a scaling multiply.
// throughput: one bin at a time; every product and quotient runs through one
// bit-serial multiply/divide unit, one bit per cycle.
// reset: arst_n clears the running sum and sets the registers to their defaults.
// ----------------------------------------------------------------------------
// anderson_darling_discrete_stat
// Streams cdf bins and emits n times the weighted squared cdf difference sum.
// ----------------------------------------------------------------------------
module anderson_darling_discrete_stat #(
	parameter int MAX_BINS      = 512,
	parameter int CDF_FRAC_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // edf_value[31:0], tdf_value[63:32]
	input  logic        s_axis_tlast,   // last_bin
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // statistic[47:0], bins_used[57:48], zeros
	output logic        m_axis_tuser    // error_flag
);

	localparam int CW = $clog2(MAX_BINS + 1);
	localparam int SH_L = (CDF_FRAC_BITS <= 32) ? 32 - CDF_FRAC_BITS : 0;
	localparam int SH_R = (CDF_FRAC_BITS > 32) ? CDF_FRAC_BITS - 32 : 0;
	localparam logic [63:0] ONE_RAW = 64'd1 << CDF_FRAC_BITS;
	localparam int QW = adds_pkg::QW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_S_M1  = 4'd2;
	localparam logic [3:0] ST_S_M2  = 4'd3;
	localparam logic [3:0] ST_S_M3  = 4'd4;
	localparam logic [3:0] ST_S_DEC = 4'd5;
	localparam logic [3:0] ST_T_M1  = 4'd6;
	localparam logic [3:0] ST_T_M2  = 4'd7;
	localparam logic [3:0] ST_T_M3  = 4'd8;
	localparam logic [3:0] ST_T_DIV = 4'd9;
	localparam logic [3:0] ST_T_RET = 4'd10;
	localparam logic [3:0] ST_ADV   = 4'd11;
	localparam logic [3:0] ST_LASTS = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;
	localparam logic [3:0] ST_O_M   = 4'd14;
	localparam logic [3:0] ST_EMIT  = 4'd15;

	function automatic logic [QW-1:0] cdf_q32(input logic [31:0] raw);
		logic [63:0] v;
		v = {32'd0, raw};
		if (v > ONE_RAW)
			v = ONE_RAW;
		v = (v << SH_L) >> SH_R;
		return v[QW-1:0];
	endfunction

	// registers
	logic [23:0] event_count_q;
	logic [31:0] step_epsilon_q;
	logic [39:0] tail_limit_q;

	logic [3:0]    state_q;
	logic          iss_q;
	logic          phase_q;    // 0: settle before advance, 1: settle on last bin
	logic          tfirst_q;
	logic [QW-1:0] e_q, t_q;
	logic          last_q;
	logic [63:0]   sum_q;
	logic [QW-1:0] pend_e_q, pend_t_q, earl_t_q;
	logic [CW-1:0] cnt_q;
	logic          stop_q, err_q;
	logic [96:0]   num_q;

	logic          out_valid_q;
	logic [47:0]   stat_q;
	logic [9:0]    bins_q;
	logic          oerr_q;

	// shared unit
	adds_pkg::alu_req_t        alu_req;
	adds_pkg::alu_rsp_t        alu_rsp;
	logic [adds_pkg::AW-1:0]   alu_a;
	logic [adds_pkg::BW-1:0]   alu_b;
	logic [adds_pkg::AW-1:0]   alu_res;

	adds_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	// datapath helpers
	logic [QW-1:0] c_val, te, tt, d_val, w_val, den_a, den_b, next_e, e_step;
	logic [63:0]   eps64;
	logic          flat, tail_small, emit_ok, alu_go;
	logic [64:0]   sum_add;
	logic [CW+9:0] cnt_ext;

	always_comb begin
		c_val  = adds_pkg::Q32_ONE - pend_t_q;
		te     = tfirst_q ? e_q : pend_e_q;
		tt     = tfirst_q ? t_q : pend_t_q;
		d_val  = (te > tt) ? te - tt : tt - te;
		w_val  = tfirst_q ? adds_pkg::Q32_ONE : ((tt > earl_t_q) ? tt - earl_t_q : '0);
		den_a  = tfirst_q ? adds_pkg::Q32_ONE : tt;
		den_b  = adds_pkg::Q32_ONE - tt;
		next_e = phase_q ? pend_e_q : e_q;
		e_step = next_e - pend_e_q;
		eps64  = ({32'd0, step_epsilon_q} << SH_L) >> SH_R;
		flat   = (next_e <= pend_e_q) || ({31'd0, e_step} <= eps64);
		tail_small = (alu_res[127:64] < {24'd0, tail_limit_q});
		sum_add    = {1'b0, sum_q} + {1'b0, alu_res[63:0]};
		emit_ok    = !out_valid_q || m_axis_tready;
		alu_go     = !iss_q;
		cnt_ext    = {10'd0, cnt_q};
	end

	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = adds_pkg::OP_MUL;
		alu_a         = '0;
		alu_b         = '0;
		unique case (state_q)
			ST_S_M1: begin
				alu_req.start = alu_go;
				alu_a = adds_pkg::AW'(c_val);
				alu_b = adds_pkg::BW'(c_val);
			end
			ST_S_M2: begin
				alu_req.start = alu_go;
				alu_a = alu_res;
				alu_b = adds_pkg::BW'(c_val);
			end
			ST_S_M3: begin
				alu_req.start = alu_go;
				alu_a = alu_res;
				alu_b = adds_pkg::BW'(event_count_q);
			end
			ST_T_M1: begin
				alu_req.start = alu_go;
				alu_a = adds_pkg::AW'(d_val);
				alu_b = adds_pkg::BW'(d_val);
			end
			ST_T_M2: begin
				alu_req.start = alu_go;
				alu_a = alu_res;
				alu_b = adds_pkg::BW'(w_val);
			end
			ST_T_M3: begin
				alu_req.start = alu_go;
				alu_a = adds_pkg::AW'(den_a);
				alu_b = adds_pkg::BW'(den_b);
			end
			ST_T_DIV: begin
				alu_req.start = alu_go;
				alu_req.op    = adds_pkg::OP_DIV;
				alu_a = adds_pkg::AW'(num_q);
				alu_b = alu_res[adds_pkg::BW-1:0];
			end
			ST_O_M: begin
				alu_req.start = alu_go;
				alu_a = adds_pkg::AW'(sum_q);
				alu_b = adds_pkg::BW'(event_count_q);
			end
			default: ;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_count_q  <= 24'd1;
			step_epsilon_q <= 32'd0;
			tail_limit_q   <= 40'd4294967;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adds_pkg::REG_EVENT_COUNT:  event_count_q  <= cfg_wdata[23:0];
				adds_pkg::REG_STEP_EPSILON: step_epsilon_q <= cfg_wdata[31:0];
				adds_pkg::REG_TAIL_LIMIT:   tail_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= 1'b0;
			phase_q     <= 1'b0;
			tfirst_q    <= 1'b0;
			e_q         <= '0;
			t_q         <= '0;
			last_q      <= 1'b0;
			sum_q       <= '0;
			pend_e_q    <= '0;
			pend_t_q    <= '0;
			earl_t_q    <= '0;
			cnt_q       <= '0;
			stop_q      <= 1'b0;
			err_q       <= 1'b0;
			num_q       <= '0;
			out_valid_q <= 1'b0;
			stat_q      <= '0;
			bins_q      <= '0;
			oerr_q      <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && emit_ok)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (alu_rsp.done)
				iss_q <= 1'b0;
			else if (alu_req.start)
				iss_q <= 1'b1;

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						e_q     <= cdf_q32(s_axis_tdata[31:0]);
						t_q     <= cdf_q32(s_axis_tdata[63:32]);
						last_q  <= s_axis_tlast;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (stop_q) begin
						state_q <= ST_FIN;
					end else if (cnt_q == '0) begin
						tfirst_q <= 1'b1;
						state_q  <= ST_T_M1;
					end else if (cnt_q >= CW'(2)) begin
						phase_q <= 1'b0;
						state_q <= ST_S_M1;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_S_M1: if (alu_rsp.done) state_q <= ST_S_M2;
				ST_S_M2: if (alu_rsp.done) state_q <= ST_S_M3;
				ST_S_M3: if (alu_rsp.done) state_q <= ST_S_DEC;
				ST_S_DEC: begin
					// flat step in a thin tail ends the sum
					if (flat && tail_small) begin
						stop_q  <= 1'b1;
						cnt_q   <= cnt_q - 1'b1;
						state_q <= phase_q ? ST_FIN : ST_ADV;
					end else begin
						tfirst_q <= 1'b0;
						state_q  <= ST_T_M1;
					end
				end
				ST_T_M1: if (alu_rsp.done) state_q <= ST_T_M2;
				ST_T_M2: begin
					if (alu_rsp.done) begin
						num_q   <= alu_res[96:0];
						state_q <= ST_T_M3;
					end
				end
				ST_T_M3: begin
					if (alu_rsp.done) begin
						if (alu_res == '0) begin
							err_q <= 1'b1;
							if (num_q != '0)
								sum_q <= '1;
							state_q <= ST_T_RET;
						end else begin
							state_q <= ST_T_DIV;
						end
					end
				end
				ST_T_DIV: begin
					if (alu_rsp.done) begin
						if (alu_res[127:64] != '0 || sum_add[64]) begin
							sum_q <= '1;
							err_q <= 1'b1;
						end else begin
							sum_q <= sum_add[63:0];
						end
						state_q <= ST_T_RET;
					end
				end
				ST_T_RET: begin
					if (tfirst_q) begin
						pend_e_q <= e_q;
						pend_t_q <= t_q;
						cnt_q    <= CW'(1);
						state_q  <= ST_FIN;
					end else begin
						state_q <= phase_q ? ST_FIN : ST_ADV;
					end
				end
				ST_ADV: begin
					if (!stop_q) begin
						if (cnt_q >= CW'(MAX_BINS)) begin
							stop_q <= 1'b1;
						end else begin
							earl_t_q <= pend_t_q;
							pend_e_q <= e_q;
							pend_t_q <= t_q;
							cnt_q    <= cnt_q + 1'b1;
						end
					end
					state_q <= ST_LASTS;
				end
				ST_LASTS: begin
					// last bin settles itself with a zero next step
					if (last_q && !stop_q && cnt_q >= CW'(2)) begin
						phase_q <= 1'b1;
						state_q <= ST_S_M1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= last_q ? ST_O_M : ST_IDLE;
				ST_O_M: if (alu_rsp.done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_ok) begin
						stat_q      <= (alu_res[127:64] != '0) ? '1 : alu_res[63:16];
						oerr_q      <= err_q || (alu_res[127:64] != '0);
						bins_q      <= cnt_ext[9:0];
						sum_q       <= '0;
						pend_e_q    <= '0;
						pend_t_q    <= '0;
						earl_t_q    <= '0;
						cnt_q       <= '0;
						stop_q      <= 1'b0;
						err_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, bins_q, stat_q};
	assign m_axis_tuser  = oerr_q;

endmodule

### test/anderson_darling_discrete_stat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anderson_darling_discrete_stat_tb
// Streams cdf bin data sets into the block, predicts every statistic word
// with a bit-accurate model of the weighted sum, and checks each output word
// in order under random source gaps, sink stalls and register settings.
// ----------------------------------------------------------------------------
module anderson_darling_discrete_stat_tb;

	localparam int MAX_BIN_COUNT = 512;
	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
	localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] STAT_SAT = 64'h0000_FFFF_FFFF_FFFF;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [47:0] statistic;
		logic [9:0]  bins_used;
		logic        error_flag;
	} stat_word_t;

	class ad_scoreboard;
		stat_word_t stat_q[$];
		int mismatches;
		logic [63:0] n_events, eps, tail_lim;
		logic [63:0] acc, cur_e, cur_t, prev_t;
		int bin_cnt;
		bit stopped, err_seen;

		function void clear_set();
			acc = 0; cur_e = 0; cur_t = 0; prev_t = 0;
			bin_cnt = 0; stopped = 0; err_seen = 0;
		endfunction

		function void reset_all();
			n_events = 1; eps = 0; tail_lim = 64'd4294967;
			clear_set();
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [39:0] val);
			case (idx)
				adds_pkg::REG_EVENT_COUNT: n_events = val[23:0];
				adds_pkg::REG_STEP_EPSILON: eps = val[31:0];
				adds_pkg::REG_TAIL_LIMIT: tail_lim = val[39:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] cdf_q32(logic [31:0] raw);
			logic [63:0] v;
			v = (raw > 32'h8000_0000) ? 64'h8000_0000 : {32'b0, raw};
			return v << 1;
		endfunction

		function void add_term(logic [63:0] e, logic [63:0] t, bit first,
				logic [63:0] tp);
			logic [127:0] d, w, num, den, q;
			logic [63:0] s;
			d = (e > t) ? e - t : t - e;
			w = first ? ONE_Q32 : ((t > tp) ? t - tp : 0);
			num = d * d * w;
			den = (first ? {64'b0, ONE_Q32} : {64'b0, t}) * {64'b0, ONE_Q32 - t};
			if (den == 0) begin
				err_seen = 1;
				if (num != 0) acc = SUM_MAX;
				return;
			end
			q = num / den;
			s = acc + q[63:0];
			if (q[127:64] != 0 || s < acc) begin
				acc = SUM_MAX;
				err_seen = 1;
			end else begin
				acc = s;
			end
		endfunction

		function void settle(logic [63:0] next_e);
			logic [127:0] c, tail;
			bit flat;
			c = ONE_Q32 - cur_t;
			tail = c * c * c * {64'b0, n_events};
			flat = (next_e <= cur_e) || (next_e - cur_e <= (eps << 1));
			if (flat && tail[127:64] < tail_lim) begin
				stopped = 1;
				bin_cnt--;
			end else begin
				add_term(cur_e, cur_t, 0, prev_t);
			end
		endfunction

		function void note_input(logic [31:0] raw_e, logic [31:0] raw_t, bit last);
			logic [63:0] e, t;
			logic [127:0] prod;
			logic [63:0] st;
			bit err;
			stat_word_t w;
			e = cdf_q32(raw_e);
			t = cdf_q32(raw_t);
			if (!stopped) begin
				if (bin_cnt == 0) begin
					add_term(e, t, 1, 0);
					cur_e = e; cur_t = t; bin_cnt = 1;
				end else begin
					if (bin_cnt >= 2) settle(e);
					if (!stopped) begin
						if (bin_cnt >= MAX_BIN_COUNT) begin
							stopped = 1;
						end else begin
							prev_t = cur_t; cur_e = e; cur_t = t; bin_cnt++;
						end
					end
					if (last && !stopped && bin_cnt >= 2) settle(cur_e);
				end
			end
			if (!last) return;
			prod = {64'b0, acc} * {64'b0, n_events};
			err = err_seen;
			if (prod[127:80] != 0) begin
				st = STAT_SAT; err = 1;
			end else begin
				st = prod[79:16];
				if (st > STAT_SAT) begin
					st = STAT_SAT; err = 1;
				end
			end
			w.statistic = st[47:0];
			w.bins_used = bin_cnt[9:0];
			w.error_flag = err;
			stat_q.push_back(w);
			clear_set();
		endfunction

		function void check_result(logic [63:0] data, logic user);
			stat_word_t w;
			if (stat_q.size() == 0) begin
				$error("unexpected output word %h", data);
				mismatches++;
				return;
			end
			w = stat_q.pop_front();
			if (data[47:0] !== w.statistic) begin
				$error("statistic: expected %h, actual %h", w.statistic, data[47:0]);
				mismatches++;
			end
			if (data[57:48] !== w.bins_used) begin
				$error("bins_used: expected %0d, actual %0d", w.bins_used, data[57:48]);
				mismatches++;
			end
			if (user !== w.error_flag) begin
				$error("error_flag: expected %b, actual %b", w.error_flag, user);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [39:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;

	ad_scoreboard sb;
	int burst_left;
	int idle_cycles;
	bit hold_req;

	anderson_darling_discrete_stat DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 0;
	end
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// sink stall pattern, with a long hold-off on request
	initial begin : sink
		int mode, left, hold;
		m_axis_tready = 0;
		mode = 0; left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold = 3000;
				m_axis_tready <= 0;
				repeat (hold) @(posedge clk);
				hold_req = 0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(16, 96);
			end
			left--;
			case (mode)
				0: m_axis_tready <= 1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [39:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_bin(logic [31:0] e, logic [31:0] t, bit last, bit no_gaps = 0);
		int gap;
		if (burst_left <= 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {t, e};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// wait until every statistic word is out and the block has gone quiet
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.stat_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] clamp_cdf(longint v);
		if (v < 0) return 0;
		if (v > 64'h8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// well-formed data set: rising theoretical cdf, empirical cdf near it
	task automatic send_set(int len, bit no_gaps = 0);
		longint t, e, stepmax;
		int k;
		logic [31:0] re, rt;
		t = $urandom_range(0, 32'h2000_0000);
		e = t;
		stepmax = 64'h8000_0000 / len;
		for (k = 0; k < len; k++) begin
			case ($urandom_range(0, 15))
				0: begin re = $urandom; rt = $urandom; end
				1: begin re = clamp_cdf(e); rt = clamp_cdf(t - $urandom_range(0, 1000)); end
				2: begin re = clamp_cdf(e - $urandom_range(0, 5000)); rt = clamp_cdf(t); end
				3: begin re = 32'h8000_0000; rt = 32'h8000_0000 - $urandom_range(0, 3); end
				default: begin
					t = t + $urandom_range(0, stepmax);
					if ($urandom_range(0, 3) != 0)
						e = t + $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
					re = clamp_cdf(e); rt = clamp_cdf(t);
				end
			endcase
			send_bin(re, rt, k == len - 1, no_gaps);
		end
	endtask

	task automatic random_regs();
		case ($urandom_range(0, 3))
			0: write_reg(adds_pkg::REG_EVENT_COUNT, 40'd1);
			1: write_reg(adds_pkg::REG_EVENT_COUNT, 40'hFF_FFFF);
			2: write_reg(adds_pkg::REG_EVENT_COUNT, 40'd0);
			default: write_reg(adds_pkg::REG_EVENT_COUNT, 40'($urandom_range(1, 24'hFF_FFFF)));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(adds_pkg::REG_STEP_EPSILON, 40'd0);
			1: write_reg(adds_pkg::REG_STEP_EPSILON, 40'h8000_0000);
			default: write_reg(adds_pkg::REG_STEP_EPSILON,
				40'($urandom_range(0, 32'h0100_0000)));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(adds_pkg::REG_TAIL_LIMIT, 40'd0);
			1: write_reg(adds_pkg::REG_TAIL_LIMIT, 40'hFF_FFFF_FFFF);
			default: write_reg(adds_pkg::REG_TAIL_LIMIT,
				{8'($urandom_range(0, 255)), $urandom});
		endcase
	endtask

	initial begin : stimulus
		int sent, len;
		bit held;
		sb = new();
		sb.reset_all();
		burst_left = 0;
		idle_cycles = 0;
		hold_req = 0;
		held = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, field extremes, zero denominators
		send_bin(32'h0, 32'h0, 1'b1);
		send_bin(32'h8000_0000, 32'h8000_0000, 1'b1);
		send_bin(32'h0, 32'h8000_0000, 1'b1);
		send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_bin(32'h8000_0000, 32'h0, 1'b1);
		send_bin(32'h1000_0000, 32'h2000_0000, 1'b0);
		send_bin(32'h3000_0000, 32'h0, 1'b0);
		send_bin(32'h2000_0000, 32'h4000_0000, 1'b0);
		send_bin(32'h2000_0000, 32'h6000_0000, 1'b1);
		send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_bin(32'h0, 32'h7FFF_FFFF, 1'b0);
		send_bin(32'h5555_5555, 32'h7FFF_FFFE, 1'b1);
		drain();
		write_reg(adds_pkg::REG_EVENT_COUNT, 40'hFF_FFFF);
		write_reg(adds_pkg::REG_STEP_EPSILON, 40'h8000_0000);
		write_reg(adds_pkg::REG_TAIL_LIMIT, 40'hFF_FFFF_FFFF);
		send_bin(32'h0100_0000, 32'h0080_0000, 1'b0);
		send_bin(32'h0200_0000, 32'h0180_0000, 1'b0);
		send_bin(32'h0300_0000, 32'h0280_0000, 1'b0);
		send_bin(32'h0400_0000, 32'h0380_0000, 1'b1);
		send_bin(32'h0, 32'h7FFF_FFFF, 1'b0);
		send_bin(32'h8000_0000, 32'h1000_0000, 1'b1);
		drain();
		write_reg(adds_pkg::REG_EVENT_COUNT, 40'd0);
		write_reg(adds_pkg::REG_STEP_EPSILON, 40'd0);
		write_reg(adds_pkg::REG_TAIL_LIMIT, 40'd0);
		send_set(3);
		drain();

		// more than the bin limit in one set
		write_reg(adds_pkg::REG_EVENT_COUNT, 40'd1000);
		send_set(MAX_BIN_COUNT + 6);
		drain();

		sent = 0;
		while (sent < 80) begin
			if ($urandom_range(0, 9) == 0) begin
				drain();
				random_regs();
			end
			if (!held && sent >= 30) begin
				// fill the block while the sink holds off
				held = 1;
				hold_req = 1;
				repeat (6) send_set($urandom_range(1, 2), 1);
				sent += 10;
			end
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			send_set(len);
			sent += len;
		end

		drain();
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
